>>> hw/rtl/hau_pkg.sv
// Shared constants, codes and types for the heading attractor update block.
// Used by hau_div and heading_attractor_update; depends on nothing else.
package hau_pkg;

  localparam int NUM_CELLS  = 64;
  localparam int HALF_CELLS = NUM_CELLS / 2;
  localparam int CW         = $clog2(NUM_CELLS);
  localparam int WAW        = $clog2(HALF_CELLS + 1);
  localparam int ACT_W      = 24;
  localparam int WGT_W      = 18;
  localparam int PROD_W     = ACT_W + 1 + WGT_W;
  localparam int ACC_W      = PROD_W + CW;
  localparam int DIV_W      = ACT_W + CW;
  localparam int DVD_W      = ACT_W + 16;
  localparam int DCNT_W     = $clog2(DVD_W);
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int CFG_W      = ACT_W;

  localparam logic [ACT_W-1:0] ACT_MAX     = {ACT_W{1'b1}};
  localparam logic [ACT_W:0]   ONE_Q16     = (ACT_W + 1)'(65536);
  localparam logic [ACT_W-1:0] INH_AMT_RST = ACT_W'(16384);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_INH_EN  = 2'd0,
    CFG_INH_AMT = 2'd1,
    CFG_NORM    = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] NORM_TOTAL = 2'd1;
  localparam logic [1:0] NORM_PEAK  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MAC,
    S_MDRAIN,
    S_COPY,
    S_CWAIT,
    S_CDEC,
    S_NRD,
    S_NLD,
    S_NDIV,
    S_FINISH
  } state_t;

endpackage

>>> hw/rtl/hau_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; has no package dependency.
module hau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/hau_div.sv
// Restoring divider, one quotient bit per cycle, for activity normalization.
// Depends on hau_pkg for the dividend and divisor widths.
module hau_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hau_pkg::DVD_W-1:0]  dividend,
  input  logic [hau_pkg::DIV_W-1:0]  divisor,
  output logic [hau_pkg::DVD_W-1:0]  quot,
  output logic                       done
);
  import hau_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DVD_W-1:0]  dvd;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    trial;
  logic              step_bit;
  logic [DIV_W-1:0]  step_rem;

  always_comb begin
    trial    = {rem, dvd[DVD_W-1]};
    step_bit = trial >= {1'b0, divisor};
    step_rem = step_bit ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DCNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      dvd  <= dividend;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      dvd  <= {dvd[DVD_W-2:0], 1'b0};
      rem  <= step_rem;
      quot <= {quot[DVD_W-2:0], step_bit};
    end
  end

endmodule

>>> hw/rtl/heading_attractor_update.sv
// One word is in work at a time.
// An update runs one multiply-accumulate per cycle over the activity and weight RAMs,
// then each cell goes through the serial divider when normalization runs.
// Reset is synchronous: activity reads as zero until the first update
// completes; the weight table is undefined until loaded.
module heading_attractor_update (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // req_type[1:0]
  input  logic [1:0]                  s_tuser,
  // cell_index[5:0], weight_value[23:6], heading_bin[29:24]
  input  logic [hau_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // read_data[23:0], last_bin[29:24], norm_fault[30], saturated[31]
  output logic [hau_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [hau_pkg::CFG_W-1:0]   cfg_data
);
  import hau_pkg::*;

  state_t state, state_next;

  logic             inh_en;
  logic [ACT_W-1:0] inh_amt;
  logic [1:0]       norm_mode;

  req_t             in_req;
  logic [5:0]       in_idx;
  logic [WGT_W-1:0] in_wgt;
  logic [5:0]       in_bin;
  logic             accept;

  logic [CW-1:0]    bin;
  logic             fault_flag;
  logic             sat_flag;
  logic             act_init;
  logic             rd_ok;
  logic [ACT_W-1:0] res_read;
  logic             out_valid;
  logic [OUT_W-1:0] out_data;
  logic             finish_fire;

  logic [CW-1:0]    ci, cj, ck;
  logic [CW-1:0]    diff;
  logic [CW:0]      wdist;

  logic             act_we, next_we, w_we;
  logic [CW-1:0]    act_waddr, act_raddr, next_raddr;
  logic [ACT_W-1:0] act_wdata, act_rdata, next_rdata, act_rd;
  logic [WAW-1:0]   w_waddr, w_raddr;
  logic [WGT_W-1:0] w_rdata;

  logic              v1, first1, last1, v2, first2, last2;
  logic [CW-1:0]     i1, j1, i2;
  logic [PROD_W-1:0] prod;
  logic [ACT_W-1:0]  old;
  logic [ACC_W-1:0]  acc, acc_sum, fin;
  logic [ACC_W-18:0] fin_sh;
  logic [ACT_W-1:0]  mac_val;
  logic              mac_sat;

  logic             cv;
  logic [CW-1:0]    ck1;
  logic [ACT_W:0]   add_val;
  logic [ACT_W-1:0] bin_val, cval;
  logic             copy_sat;
  logic [DIV_W-1:0] divsr;

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_q;
  logic [ACT_W-1:0] nval;
  logic             norm_sat;

  assign in_req   = req_t'(s_tuser);
  assign in_idx   = s_tdata[5:0];
  assign in_wgt   = s_tdata[23:6];
  assign in_bin   = s_tdata[29:24];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign finish_fire = (state == S_FINISH) && (!out_valid || m_tready);
  assign act_rd   = act_init ? act_rdata : '0;

  hau_ram #(.WIDTH(ACT_W), .DEPTH(NUM_CELLS)) u_act (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );

  hau_ram #(.WIDTH(ACT_W), .DEPTH(NUM_CELLS)) u_next (
    .clk(clk), .we(next_we), .waddr(i2), .wdata(mac_val),
    .raddr(next_raddr), .rdata(next_rdata)
  );

  hau_ram #(.WIDTH(WGT_W), .DEPTH(HALF_CELLS + 1)) u_wgt (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_wgt),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  hau_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend({act_rd, 16'b0}),
    .divisor(divsr), .quot(div_q), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inh_en    <= 1'b1;
      inh_amt   <= INH_AMT_RST;
      norm_mode <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INH_EN:  inh_en    <= cfg_data[0];
        CFG_INH_AMT: inh_amt   <= cfg_data[ACT_W-1:0];
        CFG_NORM:    norm_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req)
            REQ_UPDATE: state_next = S_MAC;
            REQ_READ:   state_next = S_RD;
            default:    state_next = S_FINISH;
          endcase
        end
      end
      S_RD:     state_next = S_FINISH;
      S_MAC:    if (ci == CW'(NUM_CELLS - 1) && cj == CW'(NUM_CELLS - 1)) state_next = S_MDRAIN;
      S_MDRAIN: if (!v1 && !v2) state_next = S_COPY;
      S_COPY:   if (ck == CW'(NUM_CELLS - 1)) state_next = S_CWAIT;
      S_CWAIT:  state_next = S_CDEC;
      S_CDEC: begin
        if ((norm_mode == NORM_TOTAL || norm_mode == NORM_PEAK) && divsr != '0) begin
          state_next = S_NRD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_NRD:    state_next = S_NLD;
      S_NLD:    state_next = S_NDIV;
      S_NDIV: begin
        if (div_done) begin
          state_next = (ck == CW'(NUM_CELLS - 1)) ? S_FINISH : S_NRD;
        end
      end
      S_FINISH: if (!out_valid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    diff    = ci - cj;
    wdist   = (diff > CW'(HALF_CELLS)) ? (CW + 1)'(NUM_CELLS) - {1'b0, diff} : {1'b0, diff};
    w_raddr = wdist[WAW-1:0];
    w_waddr = WAW'(in_idx);
    w_we    = accept && in_req == REQ_LOAD && int'(in_idx) <= HALF_CELLS;
    case (state)
      S_MAC:   act_raddr = cj;
      S_NRD:   act_raddr = ck;
      default: act_raddr = CW'(in_idx);
    endcase
    next_raddr = ck;
    div_start  = (state == S_NLD);
    nval       = (div_q > DVD_W'(ACT_MAX)) ? ACT_MAX : div_q[ACT_W-1:0];
    norm_sat   = (state == S_NDIV) && div_done && (div_q > DVD_W'(ACT_MAX));
    if (cv) begin
      act_we    = 1'b1;
      act_waddr = ck1;
      act_wdata = cval;
    end else begin
      act_we    = (state == S_NDIV) && div_done;
      act_waddr = ck;
      act_wdata = nval;
    end
  end

  always_comb begin
    acc_sum = (first2 ? '0 : acc) + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    fin     = acc_sum - ACC_W'({old, 16'b0});
    fin_sh  = fin[ACC_W-2:16];
    next_we = v2 && last2;
    if (fin[ACC_W-1]) begin
      mac_val = '0;
      mac_sat = 1'b0;
    end else if (fin_sh > (ACC_W - 17)'(ACT_MAX)) begin
      mac_val = ACT_MAX;
      mac_sat = 1'b1;
    end else begin
      mac_val = fin_sh[ACT_W-1:0];
      mac_sat = 1'b0;
    end
  end

  always_comb begin
    add_val  = (ck1 == bin) ? {1'b0, next_rdata} + ONE_Q16 : {1'b0, next_rdata};
    copy_sat = add_val[ACT_W];
    bin_val  = copy_sat ? ACT_MAX : add_val[ACT_W-1:0];
    if (inh_en) begin
      cval = (bin_val > inh_amt) ? bin_val - inh_amt : '0;
    end else begin
      cval = bin_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bin        <= '0;
      fault_flag <= 1'b0;
      sat_flag   <= 1'b0;
      act_init   <= 1'b0;
      out_valid  <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      cv         <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= (state == S_MAC);
      v2    <= v1;
      cv    <= (state == S_COPY);
      if (accept && in_req == REQ_UPDATE) begin
        bin        <= CW'(in_bin);
        fault_flag <= 1'b0;
        sat_flag   <= 1'b0;
      end else begin
        if ((next_we && mac_sat) || (cv && copy_sat) || norm_sat) begin
          sat_flag <= 1'b1;
        end
        if (state == S_CDEC && (norm_mode == NORM_TOTAL || norm_mode == NORM_PEAK)
            && divsr == '0) begin
          fault_flag <= 1'b1;
        end
      end
      if (cv && ck1 == CW'(NUM_CELLS - 1)) begin
        act_init <= 1'b1;
      end
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ci       <= '0;
      cj       <= '0;
      ck       <= '0;
      divsr    <= '0;
      res_read <= '0;
      rd_ok    <= int'(in_idx) < NUM_CELLS;
    end else begin
      if (state == S_MAC) begin
        cj <= cj + 1'b1;
        if (cj == CW'(NUM_CELLS - 1)) begin
          ci <= ci + 1'b1;
        end
      end
      if (state == S_COPY || (state == S_NDIV && div_done)) begin
        ck <= ck + 1'b1;
      end
      if (state == S_RD) begin
        res_read <= rd_ok ? act_rd : '0;
      end
      if (cv) begin
        if (norm_mode == NORM_PEAK) begin
          if (DIV_W'(cval) > divsr) begin
            divsr <= DIV_W'(cval);
          end
        end else begin
          divsr <= divsr + DIV_W'(cval);
        end
      end
    end
    i1     <= ci;
    j1     <= cj;
    first1 <= (cj == '0);
    last1  <= (cj == CW'(NUM_CELLS - 1));
    i2     <= i1;
    first2 <= first1;
    last2  <= last1;
    ck1    <= ck;
    prod   <= PROD_W'($signed({1'b0, act_rd}) * $signed(w_rdata));
    if (v1 && j1 == i1) begin
      old <= act_rd;
    end
    if (v2) begin
      acc <= acc_sum;
    end
    if (finish_fire) begin
      out_data <= {sat_flag, fault_flag, 6'(bin), res_read};
    end
  end

`ifndef SYNTHESIS
  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (!v1 && !v2))
    else $error("MAC pipeline still busy when copy pass starts");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_NDIV))
    else $error("divider finished outside the normalization wait");

  a_act_write_phase: assert property (@(posedge clk) disable iff (rst)
    act_we |-> (state == S_COPY || state == S_CWAIT || state == S_NDIV))
    else $error("activity RAM written outside copy or normalization");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (rst)
    finish_fire |=> (m_tvalid && state == S_IDLE))
    else $error("result not presented after finishing a word");
`endif

endmodule
